// ----- src/assert_macros.svh -----
// assertion helpers for the polygon clipper
// no dependencies; checks vanish when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HCL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
`define HCL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define HCL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define HCL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/hcl_pkg.sv -----
// shared types, constants and helpers of the homogeneous polygon clipper
// no dependencies
package hcl_pkg;

  localparam int unsigned CoordW      = 32;
  localparam int unsigned ResultLimit = 16;
  localparam int unsigned EmitW       = $clog2(ResultLimit + 1);
  localparam int unsigned EmitIdxW    = $clog2(ResultLimit);
  localparam int unsigned QuotW       = 31;
  localparam int unsigned QFrac       = 30;
  localparam int unsigned QDepth      = 4;
  localparam int unsigned QLevelW     = $clog2(QDepth) + 1;
  localparam logic [4:0]  DivSteps    = 5'd30;
  localparam logic [2:0]  PlaneFar    = 3'd1;
  localparam logic [2:0]  PlaneLast   = 3'd7;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [63:0]       dist_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t w;
  } vertex_t;

  typedef struct packed {
    vertex_t pos;
    logic    final_vertex;
  } in_item_t;

  typedef struct packed {
    coord_t      near_limit;
    coord_t      far_limit;
    logic [30:0] side_ratio;
    logic        side_clip_enable;
  } cfg_t;

  typedef enum logic [1:0] {
    CFG_NEAR    = 2'd0,
    CFG_FAR     = 2'd1,
    CFG_RATIO   = 2'd2,
    CFG_SIDE_EN = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [QLevelW-1:0] level;
    logic               empty;
  } fifo_stat_t;

  typedef struct packed {
    logic loading;
    logic emitting;
  } back_stat_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_INIT,
    DIV_RUN
  } div_state_t;

  typedef enum logic [4:0] {
    S_LOAD,
    S_PASS_START,
    S_FIRST_MUL,
    S_FIRST_DIST,
    S_NEXT,
    S_B_MUL,
    S_B_DIST,
    S_DECIDE,
    S_DIV_START,
    S_DIV_WAIT,
    S_IMUL,
    S_IADD,
    S_PUSH_CV,
    S_PUSH_B,
    S_STEP,
    S_PASS_END,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_WAIT
  } back_state_t;

  function automatic coord_t vtx_comp(vertex_t v, logic [1:0] k);
    coord_t c;
    unique case (k)
      2'd0: c = v.x;
      2'd1: c = v.y;
      2'd2: c = v.z;
      default: c = v.w;
    endcase
    return c;
  endfunction

endpackage

// ----- src/hcl_if.sv -----
// vertex and result channel interfaces of the polygon clipper
// no dependencies
interface hcl_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] pos_w;
  logic               final_vertex;
  modport source(output valid, pos_x, pos_y, pos_z, pos_w, final_vertex, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, pos_w, final_vertex, output ready);
endinterface

interface hcl_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_w;
  logic               end_of_polygon;
  logic               dropped_vertices;
  modport source(output valid, out_x, out_y, out_z, out_w, end_of_polygon,
                 dropped_vertices, input ready);
  modport sink(input valid, out_x, out_y, out_z, out_w, end_of_polygon,
               dropped_vertices, output ready);
endinterface

// ----- src/homogeneous_polygon_clipper.sv -----
// Homogeneous polygon clipper. Vertices stream in one per transaction and land in a four-entry
// queue, so the input can take up to four vertices while a polygon is clipped or its results drain.
// On the vertex marked final the polygon (up to BUFFER_DEPTH vertices) is clipped against the
// near and far planes and, when enabled, the six side planes, then the survivors (at most 16)
// leave one per transaction. Each clip pass walks every edge of the polygon, and each edge that
// crosses a plane also runs the bit-serial fraction divider and the interpolation multiply over the
// four components; a result waits as long as the output stalls.
`include "assert_macros.svh"

module homogeneous_polygon_clipper #(
  parameter int unsigned BUFFER_DEPTH = 16,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  hcl_in_if.sink      in_vtx,
  hcl_out_if.source   out_vtx,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_data
);
  import hcl_pkg::*;

  cfg_t       cfg_r;
  in_item_t   q_head;
  logic       q_head_valid;
  logic       q_pop;
  fifo_stat_t fstat;
  back_stat_t bstat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.near_limit       <= 32'sd65536;
      cfg_r.far_limit        <= 32'sd6553600;
      cfg_r.side_ratio       <= 31'd65536;
      cfg_r.side_clip_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_NEAR:    cfg_r.near_limit       <= $signed(cfg_data);
        CFG_FAR:     cfg_r.far_limit        <= $signed(cfg_data);
        CFG_RATIO:   cfg_r.side_ratio       <= cfg_data[30:0];
        CFG_SIDE_EN: cfg_r.side_clip_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  hcl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vtx     (in_vtx),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid),
    .stat       (fstat)
  );

  hcl_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (q_head),
    .head_valid (q_head_valid),
    .pop        (q_pop),
    .out_vtx    (out_vtx),
    .stat       (bstat)
  );

  // a polygon's results never overlap loading of the next one
  `HCL_ASSERT_IMP(a_pop_only_loading, clk, rst_n, q_pop, bstat.loading && q_head_valid)
  `HCL_ASSERT_IMP(a_no_load_while_out, clk, rst_n, bstat.emitting, !bstat.loading)
  `HCL_ASSERT_IMP(a_queue_bound, clk, rst_n, 1'b1,
    (fstat.level <= QLevelW'(QDepth)) && (fstat.empty == (fstat.level == '0)))
  `HCL_ASSERT_NXT(a_gap_after_last, clk, rst_n,
    out_vtx.valid && out_vtx.ready && out_vtx.end_of_polygon, !out_vtx.valid)

endmodule

// ----- src/hcl_front.sv -----
// front end: takes vertex transactions and queues them for the clip engine
// depends on hcl_pkg and hcl_if
module hcl_front (
  input  logic               clk,
  input  logic               rst_n,
  hcl_in_if.sink             in_vtx,
  input  logic               pop,
  output hcl_pkg::in_item_t  head,
  output logic               head_valid,
  output hcl_pkg::fifo_stat_t stat
);
  import hcl_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  in_item_t           q_r [QDepth];
  logic [PtrW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QLevelW-1:0] level_r, level_nxt;
  logic               push;

  assign in_vtx.ready = (level_r != QLevelW'(QDepth));
  assign push         = in_vtx.valid && in_vtx.ready;
  assign head_valid   = (level_r != '0);
  assign head         = q_r[rd_ptr_r];
  assign stat.level   = level_r;
  assign stat.empty   = !head_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    level_nxt  = level_r;
    if (push && !pop) begin
      level_nxt = level_r + 1'b1;
    end else if (pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{pos: '{x: in_vtx.pos_x, y: in_vtx.pos_y, z: in_vtx.pos_z,
                                w: in_vtx.pos_w},
                         final_vertex: in_vtx.final_vertex};
    end
  end

endmodule

// ----- src/hcl_div.sv -----
// restoring divider giving the crossing fraction |da|/(|da|+|db|) in Q1.30
// depends on hcl_pkg
module hcl_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [63:0]              ua,
  input  logic [63:0]              ub,
  output logic                     done,
  output logic [hcl_pkg::QuotW-1:0] quot
);
  import hcl_pkg::*;

  div_state_t       state_r, state_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [63:0]      den_r, rem_r;
  logic [QuotW-1:0] q_r;
  logic [64:0]      init_diff;
  logic [65:0]      step_diff;

  assign done = done_r;
  assign quot = q_r;

  assign init_diff = {1'b0, rem_r} - {1'b0, den_r};
  // 2r - den; the borrow bit says the remainder stays doubled
  assign step_diff = {1'b0, rem_r, 1'b0} - {2'b00, den_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      DIV_IDLE: begin
        if (start) begin
          state_nxt = DIV_INIT;
        end
      end
      DIV_INIT: begin
        cnt_nxt   = DivSteps;
        state_nxt = DIV_RUN;
      end
      DIV_RUN: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == 5'd1) begin
          done_nxt  = 1'b1;
          state_nxt = DIV_IDLE;
        end
      end
      default: state_nxt = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      DIV_IDLE: begin
        if (start) begin
          den_r <= ua + ub;
          rem_r <= ua;
        end
      end
      DIV_INIT: begin
        if (!init_diff[64]) begin
          rem_r <= init_diff[63:0];
          q_r   <= QuotW'(1);
        end else begin
          q_r   <= '0;
        end
      end
      DIV_RUN: begin
        if (!step_diff[65]) begin
          rem_r <= step_diff[63:0];
          q_r   <= {q_r[QuotW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[62:0], 1'b0};
          q_r   <= {q_r[QuotW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- src/hcl_back.sv -----
// back end: polygon buffers, plane-by-plane clip engine and result register
// depends on hcl_pkg, hcl_if and hcl_div
module hcl_back #(
  parameter int unsigned BUFFER_DEPTH = 16,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hcl_pkg::cfg_t      cfg,
  input  hcl_pkg::in_item_t  head,
  input  logic               head_valid,
  output logic               pop,
  hcl_out_if.source          out_vtx,
  output hcl_pkg::back_stat_t stat
);
  import hcl_pkg::*;

  localparam int unsigned AW       = $clog2(BUFFER_DEPTH);
  localparam int unsigned CntW     = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned EW       = (CntW > EmitW) ? CntW : EmitW;
  localparam int unsigned MemDepth = 2 ** (AW + 1);
  localparam dist_t       RoundHalf = dist_t'(1) <<< (QFrac - 1);

  // two banks, addressed by {bank, index}
  vertex_t     mem [MemDepth];
  logic        wr_en;
  logic [AW:0] wr_addr, rd_addr;
  vertex_t     wr_data, rd_data_r;

  back_state_t         state_r, state_nxt;
  logic [2:0]          plane_r, plane_nxt;
  logic                bank_r, bank_nxt;
  logic [CntW-1:0]     n_r, n_nxt;
  logic [CntW-1:0]     i_r, i_nxt;
  logic [CntW-1:0]     dcnt_r, dcnt_nxt;
  logic [CntW-1:0]     vcnt_r, vcnt_nxt;
  logic                ovf_r, ovf_nxt;
  logic                drop_r, drop_nxt;
  logic [1:0]          k_r, k_nxt;
  logic [EmitIdxW-1:0] e_r, e_nxt;
  logic [EmitIdxW-1:0] emit_last_r, emit_last_nxt;
  logic                ovalid_r, ovalid_nxt;

  vertex_t a_r, b_r, first_r, odata_r;
  coord_t  cv_r [4];
  dist_t   da_r, db_r, dfirst_r, rw_r, cterm_r, lin_r, prod_r;
  logic    oend_r, odrop_r;

  logic               push;
  vertex_t            push_data;
  logic [CntW-1:0]    ip1;
  logic [2:0]         plane_end;
  logic               a_in, b_in;
  coord_t             coord_sel, a_k, b_k;
  logic signed [31:0] ratio_s, q_s;
  logic signed [32:0] diff;
  dist_t              cterm_raw, lin_raw, dist_now, rnd;
  logic               div_start, div_done;
  logic [QuotW-1:0]   quot;
  logic [63:0]        ua, ub;

  hcl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .ua    (ua),
    .ub    (ub),
    .done  (div_done),
    .quot  (quot)
  );

  assign ua = da_r[63] ? unsigned'(-da_r) : unsigned'(da_r);
  assign ub = db_r[63] ? unsigned'(-db_r) : unsigned'(db_r);

  assign ip1       = i_r + 1'b1;
  assign plane_end = cfg.side_clip_enable ? PlaneLast : PlaneFar;
  assign a_in      = da_r[63] || (da_r == '0);
  assign b_in      = db_r[63] || (db_r == '0);

  // plane distance: near/far are linear in w, side planes are +-c*2^F - r*w
  assign coord_sel = vtx_comp(rd_data_r, plane_r[2:1] - 2'd1);
  assign cterm_raw = dist_t'(coord_sel) <<< FRAC_BITS;
  assign lin_raw   = plane_r[0] ? (dist_t'(rd_data_r.w) - dist_t'(cfg.far_limit))
                                : (dist_t'(cfg.near_limit) - dist_t'(rd_data_r.w));
  assign ratio_s   = $signed({1'b0, cfg.side_ratio});
  assign dist_now  = (plane_r[2:1] == 2'b00) ? lin_r : (cterm_r - rw_r);

  assign a_k  = vtx_comp(a_r, k_r);
  assign b_k  = vtx_comp(b_r, k_r);
  assign diff = $signed({b_k[31], b_k}) - $signed({a_k[31], a_k});
  assign q_s  = $signed({1'b0, quot});
  assign rnd  = (prod_r + RoundHalf) >>> QFrac;

  assign out_vtx.valid            = ovalid_r;
  assign out_vtx.out_x            = odata_r.x;
  assign out_vtx.out_y            = odata_r.y;
  assign out_vtx.out_z            = odata_r.z;
  assign out_vtx.out_w            = odata_r.w;
  assign out_vtx.end_of_polygon   = oend_r;
  assign out_vtx.dropped_vertices = odrop_r;

  assign stat.loading  = (state_r == S_LOAD);
  assign stat.emitting = ovalid_r;

  always_comb begin
    state_nxt     = state_r;
    plane_nxt     = plane_r;
    bank_nxt      = bank_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    dcnt_nxt      = dcnt_r;
    vcnt_nxt      = vcnt_r;
    ovf_nxt       = ovf_r;
    drop_nxt      = drop_r;
    k_nxt         = k_r;
    e_nxt         = e_r;
    emit_last_nxt = emit_last_r;
    ovalid_nxt    = ovalid_r;
    pop           = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = {1'b0, vcnt_r[AW-1:0]};
    wr_data       = head.pos;
    rd_addr       = {bank_r, ip1[AW-1:0]};
    div_start     = 1'b0;
    push          = 1'b0;
    push_data     = b_r;

    unique case (state_r)
      S_LOAD: begin
        if (head_valid) begin
          pop = 1'b1;
          if (vcnt_r < CntW'(BUFFER_DEPTH)) begin
            wr_en    = 1'b1;
            vcnt_nxt = vcnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (head.final_vertex) begin
            n_nxt     = vcnt_nxt;
            drop_nxt  = ovf_nxt;
            plane_nxt = '0;
            bank_nxt  = 1'b0;
            vcnt_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_PASS_START;
          end
        end
      end
      S_PASS_START: begin
        rd_addr   = {bank_r, {AW{1'b0}}};
        dcnt_nxt  = '0;
        i_nxt     = '0;
        state_nxt = S_FIRST_MUL;
      end
      S_FIRST_MUL:  state_nxt = S_FIRST_DIST;
      S_FIRST_DIST: state_nxt = S_NEXT;
      S_NEXT: begin
        // the closing edge reuses the first vertex and its distance
        state_nxt = (ip1 < n_r) ? S_B_MUL : S_DECIDE;
      end
      S_B_MUL:  state_nxt = S_B_DIST;
      S_B_DIST: state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (a_in && b_in) begin
          state_nxt = S_PUSH_B;
        end else if (a_in != b_in) begin
          state_nxt = S_DIV_START;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_DIV_START: begin
        div_start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          k_nxt     = '0;
          state_nxt = S_IMUL;
        end
      end
      S_IMUL: state_nxt = S_IADD;
      S_IADD: begin
        k_nxt     = k_r + 1'b1;
        state_nxt = (k_r == 2'd3) ? S_PUSH_CV : S_IMUL;
      end
      S_PUSH_CV: begin
        push      = 1'b1;
        push_data = '{x: cv_r[0], y: cv_r[1], z: cv_r[2], w: cv_r[3]};
        state_nxt = a_in ? S_STEP : S_PUSH_B;
      end
      S_PUSH_B: begin
        push      = 1'b1;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        i_nxt     = ip1;
        state_nxt = (ip1 == n_r) ? S_PASS_END : S_NEXT;
      end
      S_PASS_END: begin
        bank_nxt = !bank_r;
        n_nxt    = dcnt_r;
        if (dcnt_r == '0) begin
          state_nxt = S_LOAD;
        end else if (plane_r == plane_end) begin
          if (EW'(dcnt_r) > EW'(ResultLimit)) begin
            emit_last_nxt = EmitIdxW'(ResultLimit - 1);
            drop_nxt      = 1'b1;
          end else begin
            emit_last_nxt = EmitIdxW'(dcnt_r - 1'b1);
          end
          e_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          plane_nxt = plane_r + 1'b1;
          state_nxt = S_PASS_START;
        end
      end
      S_EMIT_RD: begin
        rd_addr   = {bank_r, AW'(e_r)};
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        ovalid_nxt = 1'b1;
        state_nxt  = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (out_vtx.ready) begin
          ovalid_nxt = 1'b0;
          if (e_r == emit_last_r) begin
            state_nxt = S_LOAD;
          end else begin
            e_nxt     = e_r + 1'b1;
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase

    // vertices beyond the buffer are lost and flagged
    if (push) begin
      if (dcnt_r < CntW'(BUFFER_DEPTH)) begin
        wr_en    = 1'b1;
        wr_addr  = {!bank_r, dcnt_r[AW-1:0]};
        wr_data  = push_data;
        dcnt_nxt = dcnt_r + 1'b1;
      end else begin
        drop_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      plane_r     <= '0;
      bank_r      <= 1'b0;
      n_r         <= '0;
      i_r         <= '0;
      dcnt_r      <= '0;
      vcnt_r      <= '0;
      ovf_r       <= 1'b0;
      drop_r      <= 1'b0;
      k_r         <= '0;
      e_r         <= '0;
      emit_last_r <= '0;
      ovalid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      plane_r     <= plane_nxt;
      bank_r      <= bank_nxt;
      n_r         <= n_nxt;
      i_r         <= i_nxt;
      dcnt_r      <= dcnt_nxt;
      vcnt_r      <= vcnt_nxt;
      ovf_r       <= ovf_nxt;
      drop_r      <= drop_nxt;
      k_r         <= k_nxt;
      e_r         <= e_nxt;
      emit_last_r <= emit_last_nxt;
      ovalid_r    <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    case (state_r) inside
      S_FIRST_MUL, S_B_MUL: begin
        b_r     <= rd_data_r;
        rw_r    <= ratio_s * rd_data_r.w;
        cterm_r <= plane_r[0] ? -cterm_raw : cterm_raw;
        lin_r   <= lin_raw;
      end
      S_FIRST_DIST: begin
        a_r      <= b_r;
        first_r  <= b_r;
        da_r     <= dist_now;
        dfirst_r <= dist_now;
      end
      S_B_DIST: db_r <= dist_now;
      S_NEXT: begin
        if (!(ip1 < n_r)) begin
          b_r  <= first_r;
          db_r <= dfirst_r;
        end
      end
      S_IMUL: prod_r <= diff * q_s;
      S_IADD: cv_r[k_r] <= a_k + rnd[31:0];
      S_STEP: begin
        a_r  <= b_r;
        da_r <= db_r;
      end
      S_EMIT_LD: begin
        odata_r <= rd_data_r;
        oend_r  <= (e_r == emit_last_r);
        odrop_r <= drop_r;
      end
      default: ;
    endcase
  end

endmodule
